/* design/bdte_pkg.sv */
// types, constants and helper functions shared by the bcd date-time converter
package bdte_pkg;

    localparam logic [4:0] TZ_RESET = 5'd9;

    // tens-digit limits per field
    localparam logic [3:0] YEAR_TENS_LIM   = 4'd10;
    localparam logic [3:0] MONTH_TENS_LIM  = 4'd2;
    localparam logic [3:0] DAY_TENS_LIM    = 4'd4;
    localparam logic [3:0] HOUR_TENS_LIM   = 4'd3;
    localparam logic [3:0] MINSEC_TENS_LIM = 4'd6;
    localparam logic [3:0] UNITS_LIM       = 4'd10;

    localparam logic [7:0] Y2K_SPLIT = 8'd70;

    typedef struct packed {
        logic [7:0] year_bcd;
        logic [7:0] month_bcd;
        logic [7:0] day_bcd;
        logic [7:0] hour_bcd;
        logic [7:0] minute_bcd;
        logic [7:0] second_bcd;
    } in_t;

    typedef struct packed {
        logic signed [31:0] epoch_seconds;
        logic               digit_fault;
    } out_t;

    // decoded transaction between the two register stages
    typedef struct packed {
        logic               fault;
        logic signed [16:0] days;
        logic signed [17:0] sod;
    } stage_t;

    function automatic logic digits_ok(input logic [7:0] b, input logic [3:0] tens_lim);
        return (b[7:4] < tens_lim) && (b[3:0] < UNITS_LIM);
    endfunction

    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/bdte_decode.sv */
// first stage logic: digit checks, bcd decode, day count and second of day
module bdte_decode (
    input  bdte_pkg::in_t    in_data,
    input  logic [4:0]       tz,
    output bdte_pkg::stage_t stage
);
    import bdte_pkg::*;

    logic [7:0]  y;
    logic [7:0]  mo;
    logic [7:0]  d;
    logic [7:0]  h;
    logic [7:0]  mi;
    logic [7:0]  s;
    logic [6:0]  year_base;
    logic [6:0]  year_off;
    logic [3:0]  mon_idx;
    logic        leap_add;
    logic [15:0] year_days;
    logic [4:0]  quads;
    logic [15:0] pos_days;
    logic [16:0] hms;
    logic [16:0] tz_secs;

    always_comb
    begin
        y  = bcd_val(in_data.year_bcd);
        mo = bcd_val(in_data.month_bcd);
        d  = bcd_val(in_data.day_bcd);
        h  = bcd_val(in_data.hour_bcd);
        mi = bcd_val(in_data.minute_bcd);
        s  = bcd_val(in_data.second_bcd);

        // year counted from 1968 so that leap years have the low two bits clear
        year_base = (y < Y2K_SPLIT) ? (y[6:0] + 7'd32) : (y[6:0] - 7'd68);

        // month zero is december of the year before, 13..19 wrap into the next
        if (mo == 8'd0)
        begin
            mon_idx  = 4'd11;
            year_off = year_base - 7'd1;
        end
        else if (mo >= 8'd13)
        begin
            mon_idx  = 4'(mo - 8'd13);
            year_off = year_base + 7'd1;
        end
        else
        begin
            mon_idx  = 4'(mo - 8'd1);
            year_off = year_base;
        end

        leap_add  = (mon_idx >= 4'd2) && (year_off[1:0] == 2'b00);
        year_days = 16'(year_off) * 16'd365;
        quads     = 5'((year_off - 7'd1) >> 2);
        pos_days  = year_days + 16'(quads) + 16'(days_before_month(mon_idx))
                  + 16'(leap_add) + 16'(d);

        hms     = 17'(h) * 17'd3600 + 17'(mi) * 17'd60 + 17'(s);
        tz_secs = 17'(tz) * 17'd3600;

        stage.fault = !(digits_ok(in_data.year_bcd,   YEAR_TENS_LIM)
                     && digits_ok(in_data.month_bcd,  MONTH_TENS_LIM)
                     && digits_ok(in_data.day_bcd,    DAY_TENS_LIM)
                     && digits_ok(in_data.hour_bcd,   HOUR_TENS_LIM)
                     && digits_ok(in_data.minute_bcd, MINSEC_TENS_LIM)
                     && digits_ok(in_data.second_bcd, MINSEC_TENS_LIM));
        // 731 = two years from 1968 plus the day-of-month offset of one
        stage.days  = $signed({1'b0, pos_days}) - 17'sd731;
        stage.sod   = $signed({1'b0, hms}) - $signed({1'b0, tz_secs});
    end

endmodule

/* design/bdte_combine.sv */
// second stage: days times 86400 plus second of day, wrapped; zero on a fault
module bdte_combine (
    input  bdte_pkg::stage_t stage,
    output bdte_pkg::out_t   result
);
    import bdte_pkg::*;

    logic signed [31:0] days_w;
    logic signed [31:0] day_secs;

    always_comb
    begin
        days_w   = 32'(stage.days);
        day_secs = days_w * 32'sd86400;
        if (stage.fault)
        begin
            result.epoch_seconds = 32'sd0;
            result.digit_fault   = 1'b1;
        end
        else
        begin
            result.epoch_seconds = day_secs + 32'(stage.sod);
            result.digit_fault   = 1'b0;
        end
    end

endmodule

/* design/bcd_datetime_to_epoch_unit.sv */
// top level of the bcd date-time to epoch seconds converter
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_data  (bdte_pkg::in_t)
//  out      output     out_valid / out_stall out_data (bdte_pkg::out_t)
//  cfg      input      cfg_wr_en             cfg_wr_data (timezone hours)
//
// one transaction per cycle sustained while out_stall is low; an accepted
// transaction passes a decode register holding the day count and second
// of day, then the result register after the days-times-86400 multiply.
// reset clears both valid flags and loads the timezone offset with 9 hours.
// out_stall holds the result register; the decode register keeps taking
// transactions until it too is full, then in_stall rises.
module bcd_datetime_to_epoch_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bdte_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output bdte_pkg::out_t out_data,
    input  logic           cfg_wr_en,
    input  logic [4:0]     cfg_wr_data
);
    import bdte_pkg::*;

    logic [4:0] tz_reg;
    logic       s1_valid_reg;
    stage_t     s1_reg;
    stage_t     s1_next;
    logic       out_valid_reg;
    out_t       out_reg;
    out_t       out_next;
    logic       out_load;
    logic       s1_load;

    bdte_decode u_decode (
        .in_data (in_data),
        .tz      (tz_reg),
        .stage   (s1_next)
    );

    bdte_combine u_combine (
        .stage  (s1_reg),
        .result (out_next)
    );

    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_load   = !s1_valid_reg || out_load;
    assign in_stall  = !s1_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg        <= TZ_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                tz_reg <= cfg_wr_data;
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
            s1_reg <= s1_next;
        if (out_load && s1_valid_reg)
            out_reg <= out_next;
    end

    a_fault_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.digit_fault |-> out_data.epoch_seconds == 32'sd0)
        else $error("fault result carries a nonzero count");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted transaction lost in decode stage");

    a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && s1_valid_reg |-> in_stall)
        else $error("input taken while both stages are full");

    a_move_on : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !(out_valid && out_stall) |=> out_valid)
        else $error("decoded transaction not moved to result register");

endmodule
